// ===== hw/rtl/vdp_cpu_port_interface_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the VDP CPU port interface
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef VDP_CPU_PORT_INTERFACE_ASSERT_SVH
`define VDP_CPU_PORT_INTERFACE_ASSERT_SVH

// same-cycle implication
`define VDP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vdp assertion failed");

// next-cycle implication
`define VDP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vdp assertion failed");

`endif

// ===== hw/rtl/vdp_pkg.sv =====
// ---------------------------------------------------------------------------
// vdp_pkg
// Request codes, interrupt actions and controller/datapath interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package vdp_pkg;

  localparam logic [2:0] REQ_RD_DATA   = 3'd0;
  localparam logic [2:0] REQ_RD_STATUS = 3'd1;
  localparam logic [2:0] REQ_WR_DATA   = 3'd2;
  localparam logic [2:0] REQ_WR_CTRL   = 3'd3;
  localparam logic [2:0] REQ_TICK      = 3'd4;

  localparam logic [1:0] NMI_NONE    = 2'd0;
  localparam logic [1:0] NMI_ASSERT  = 2'd1;
  localparam logic [1:0] NMI_RELEASE = 2'd2;

  localparam logic [8:0] VBLANK_LINE    = 9'd192;
  localparam int unsigned IRQ_ENABLE_POS = 5;
  localparam logic [2:0] MODE_REG_IRQ   = 3'd1;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic fetch_load;
    logic clear_wr;
  } vdp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_fetch;
    logic clear_last;
  } vdp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vdp_dp.sv =====
// ---------------------------------------------------------------------------
// vdp_dp
// Video RAM, address/read-ahead registers, control latch, status and result.
// ---------------------------------------------------------------------------
`default_nettype none

module vdp_dp #(
  parameter int unsigned VRAM_DEPTH = 16384
) (
  input  wire               clk,
  input  wire               rst,
  input  vdp_pkg::vdp_cmd_t cmd,
  output vdp_pkg::vdp_sts_t sts,
  input  wire  [2:0]        req_type,
  input  wire  [7:0]        wr_data,
  input  wire  [8:0]        line_number,
  output logic [7:0]        rd_data,
  output logic [1:0]        nmi_action,
  output logic              irq_pending
);
  import vdp_pkg::*;

  localparam int unsigned AW = $clog2(VRAM_DEPTH);

  logic [7:0]    mem [VRAM_DEPTH];
  logic [7:0]    ram_q;
  logic [AW-1:0] vram_address;
  logic [AW-1:0] vram_address_next;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] ram_raddr;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] new_addr;
  logic [15:0]   ctrl_word;
  logic          ram_we;
  logic [7:0]    ram_wdata;
  logic [7:0]    read_ahead;
  logic          latch_pending;
  logic [7:0]    latched_byte;
  logic          vblank;
  logic          irq_enable;
  logic [9:0]    current_line;
  logic          is_ctrl2;
  logic          set_addr;
  logic          set_mode;
  logic          at_vblank_line;
  logic [7:0]    rd_next;
  logic [1:0]    nmi_next;
  logic          irq_next;

  assign ctrl_word      = {wr_data, latched_byte};
  assign new_addr       = ctrl_word[AW-1:0];
  assign is_ctrl2       = (req_type == REQ_WR_CTRL) && latch_pending;
  assign set_addr       = is_ctrl2 && !wr_data[7];
  assign set_mode       = is_ctrl2 && wr_data[7];
  assign at_vblank_line = (line_number == VBLANK_LINE);

  assign sts.need_fetch = (req_type == REQ_RD_DATA) || (set_addr && !wr_data[6]);
  assign sts.clear_last = &clr_addr;

  // memory ports
  assign ram_raddr = set_addr ? new_addr : vram_address;
  assign ram_we    = cmd.clear_wr || (cmd.accept && (req_type == REQ_WR_DATA));
  assign ram_waddr = cmd.clear_wr ? clr_addr : vram_address;
  assign ram_wdata = cmd.clear_wr ? 8'h00 : wr_data;

  always_ff @(posedge clk) begin
    if (ram_we) begin
      mem[ram_waddr] <= ram_wdata;
    end
    ram_q <= mem[ram_raddr];
  end

  always_comb begin
    vram_address_next = vram_address;
    case (req_type)
      REQ_RD_DATA, REQ_WR_DATA: begin
        vram_address_next = vram_address + AW'(1);
      end
      REQ_WR_CTRL: begin
        if (set_addr) begin
          vram_address_next = new_addr + {{(AW-1){1'b0}}, !wr_data[6]};
        end
      end
      default: begin
        vram_address_next = vram_address;
      end
    endcase
  end

  always_comb begin
    rd_next  = 8'h00;
    nmi_next = NMI_NONE;
    irq_next = 1'b0;
    case (req_type)
      REQ_RD_DATA: begin
        rd_next = read_ahead;
      end
      REQ_RD_STATUS: begin
        rd_next  = {vblank, 7'b0};
        nmi_next = NMI_RELEASE;
      end
      REQ_WR_CTRL: begin
        if (set_mode && (wr_data[2:0] == MODE_REG_IRQ) && latched_byte[IRQ_ENABLE_POS]
            && vblank && (current_line != {1'b0, VBLANK_LINE})) begin
          nmi_next = NMI_ASSERT;
        end
      end
      REQ_TICK: begin
        if (at_vblank_line && irq_enable) begin
          nmi_next = NMI_ASSERT;
        end
        irq_next = (vblank || at_vblank_line) && irq_enable;
      end
      default: begin
        rd_next = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // only the interrupt enable of the mode registers is observable here
  always_ff @(posedge clk) begin
    if (rst) begin
      vram_address  <= '0;
      read_ahead    <= 8'h00;
      latch_pending <= 1'b0;
      latched_byte  <= 8'h00;
      vblank        <= 1'b0;
      irq_enable    <= 1'b0;
      current_line  <= 10'd0;
    end else begin
      if (cmd.fetch_load) begin
        read_ahead <= ram_q;
      end
      if (cmd.accept) begin
        vram_address <= vram_address_next;
        case (req_type)
          REQ_RD_DATA: begin
            latch_pending <= 1'b0;
          end
          REQ_RD_STATUS: begin
            latch_pending <= 1'b0;
            vblank        <= 1'b0;
          end
          REQ_WR_DATA: begin
            latch_pending <= 1'b0;
            read_ahead    <= wr_data;
          end
          REQ_WR_CTRL: begin
            latch_pending <= !latch_pending;
            if (!latch_pending) begin
              latched_byte <= wr_data;
            end
            if (set_mode && (wr_data[2:0] == MODE_REG_IRQ)) begin
              irq_enable <= latched_byte[IRQ_ENABLE_POS];
            end
          end
          REQ_TICK: begin
            current_line <= {1'b0, line_number} + 10'd1;
            if (at_vblank_line) begin
              vblank <= 1'b1;
            end
          end
          default: begin
            latch_pending <= latch_pending;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data     <= rd_next;
      nmi_action  <= nmi_next;
      irq_pending <= irq_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vdp_ctrl.sv =====
// ---------------------------------------------------------------------------
// vdp_ctrl
// Sequencer: RAM clearing pass, word acceptance, read-ahead fetch, output valid.
// ---------------------------------------------------------------------------
`default_nettype none

module vdp_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  wire               m_tready,
  output vdp_pkg::vdp_cmd_t cmd,
  input  vdp_pkg::vdp_sts_t sts
);
  import vdp_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign s_tready       = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept         = s_tvalid && s_tready;
  assign cmd.accept     = accept;
  assign cmd.fetch_load = (state == ST_FETCH);
  assign cmd.clear_wr   = (state == ST_CLEAR);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && sts.need_fetch) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`include "vdp_cpu_port_interface_assert.svh"

  `VDP_ASSERT_NEXT(a_fetch_follows, accept && sts.need_fetch, state == ST_FETCH)
  `VDP_ASSERT_NEXT(a_fetch_one_cycle, state == ST_FETCH, state == ST_IDLE)
  `VDP_ASSERT_NEXT(a_result_after_accept, accept, m_tvalid)
  `VDP_ASSERT_NEXT(a_clear_holds, (state == ST_CLEAR) && !sts.clear_last, state == ST_CLEAR)
  `VDP_ASSERT_IMP(a_no_accept_busy, state != ST_IDLE, !accept)

endmodule

`default_nettype wire

// ===== hw/rtl/vdp_cpu_port_interface.sv =====
// ---------------------------------------------------------------------------
// vdp_cpu_port_interface
// CPU data/control/status ports of a video display processor with scanline tick.
// ---------------------------------------------------------------------------
//   channel  direction  tuser      tdata
//   s_*      in         req_type   wr_data, line_number
//   m_*      out        -          rd_data, nmi_action, irq_pending
//
// Data reads and second control bytes that load an address with bit 6 clear
// are followed by a fetch state that loads the read-ahead byte from the
// registered VRAM read port; no word is taken during it. Other words need no
// fetch. A result waits in the output register; the next word is taken once
// that register is empty or being drained.
// After reset the VRAM is cleared one byte a cycle (VRAM_DEPTH bytes, 16384
// by default) and no word is accepted until the pass is done.
// ---------------------------------------------------------------------------
`default_nettype none

module vdp_cpu_port_interface #(
  parameter int unsigned VRAM_DEPTH = 16384
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,   // wr_data[7:0], line_number[16:8], zero pad
  input  wire  [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata    // rd_data[7:0], nmi_action[9:8], irq_pending[10], zero pad
);
  import vdp_pkg::*;

  vdp_cmd_t   cmd;
  vdp_sts_t   sts;
  logic [7:0] rd_data;
  logic [1:0] nmi_action;
  logic       irq_pending;

  vdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  vdp_dp #(
    .VRAM_DEPTH (VRAM_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (s_tuser),
    .wr_data     (s_tdata[7:0]),
    .line_number (s_tdata[16:8]),
    .rd_data     (rd_data),
    .nmi_action  (nmi_action),
    .irq_pending (irq_pending)
  );

  assign m_tdata = {5'b0, irq_pending, nmi_action, rd_data};

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the VDP CPU port interface
// Sends data/status/control/tick words over the input stream, mirrors the
// VRAM, address, read-ahead, latch, mode and status state in a local model,
// and compares every output word field by field against the model's result.
// Both stream sides idle at random; one phase stalls the output for a long
// stretch so the block backs up and stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vdp_pkg::*;

  localparam int unsigned VRAM_DEPTH     = 16384;
  localparam int unsigned VBLANK_POS     = 7;
  localparam logic [7:0]  STATUS_KEEP    = 8'h1f;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic       irq_pending;
    logic [1:0] nmi_action;
    logic [7:0] rd_data;
  } vdp_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // wr_data[7:0], line_number[16:8], zero pad
  logic [2:0]  s_tuser;   // req_type[2:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // rd_data[7:0], nmi_action[9:8], irq_pending[10], zero pad

  // shadow of the port state
  logic [7:0]  vram_shadow [VRAM_DEPTH];
  logic [13:0] addr_shadow;
  logic [7:0]  ahead_shadow;
  logic        second_byte_due;
  logic [7:0]  held_byte;
  logic [7:0]  mode_shadow [8];
  logic [7:0]  status_shadow;
  logic [9:0]  line_shadow;

  vdp_result_t expected_results[$];
  int unsigned words_sent;
  int unsigned mismatch_count;
  int unsigned hold_left;
  logic        tx_idle_on;
  logic        rx_idle_on;

  vdp_cpu_port_interface #(.VRAM_DEPTH(VRAM_DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  task automatic clear_shadow();
    foreach (vram_shadow[i]) vram_shadow[i] = 8'h00;
    foreach (mode_shadow[i]) mode_shadow[i] = 8'h00;
    addr_shadow     = '0;
    ahead_shadow    = '0;
    second_byte_due = 1'b0;
    held_byte       = '0;
    status_shadow   = '0;
    line_shadow     = '0;
  endtask

  function automatic void fetch_ahead();
    ahead_shadow = vram_shadow[addr_shadow];
    addr_shadow  = addr_shadow + 14'd1;
  endfunction

  // Apply one word to the shadow state and return the word it produces.
  function automatic vdp_result_t predict_port_word(logic [2:0] req, logic [7:0] wr,
                                                    logic [8:0] line);
    vdp_result_t r;
    r = '0;
    case (req)
      REQ_RD_DATA: begin
        r.rd_data = ahead_shadow;
        fetch_ahead();
        second_byte_due = 1'b0;
      end
      REQ_RD_STATUS: begin
        r.rd_data       = status_shadow;
        r.nmi_action    = NMI_RELEASE;
        status_shadow   = status_shadow & STATUS_KEEP;
        second_byte_due = 1'b0;
      end
      REQ_WR_DATA: begin
        ahead_shadow             = wr;
        vram_shadow[addr_shadow] = wr;
        addr_shadow              = addr_shadow + 14'd1;
        second_byte_due          = 1'b0;
      end
      REQ_WR_CTRL: begin
        if (second_byte_due) begin
          if (wr[7]) begin
            mode_shadow[wr[2:0]] = held_byte;
            if (wr[2:0] == MODE_REG_IRQ && held_byte[IRQ_ENABLE_POS] &&
                status_shadow[VBLANK_POS] && line_shadow != 10'(VBLANK_LINE))
              r.nmi_action = NMI_ASSERT;
          end else begin
            addr_shadow = {wr[5:0], held_byte};
            if (!wr[6]) fetch_ahead();
          end
          second_byte_due = 1'b0;
        end else begin
          held_byte       = wr;
          second_byte_due = 1'b1;
        end
      end
      REQ_TICK: begin
        line_shadow = 10'(line);
        if (line == VBLANK_LINE) begin
          status_shadow[VBLANK_POS] = 1'b1;
          if (mode_shadow[MODE_REG_IRQ][IRQ_ENABLE_POS]) r.nmi_action = NMI_ASSERT;
        end
        line_shadow   = line_shadow + 10'd1;
        r.irq_pending = status_shadow[VBLANK_POS] &
                        mode_shadow[MODE_REG_IRQ][IRQ_ENABLE_POS];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(input logic [2:0] req, input logic [7:0] wr,
                           input logic [8:0] line);
    while (tx_idle_on && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {7'd0, line, wr};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_port_word(req, wr, line));
    words_sent++;
  endtask

  // Output side: a long hold-off while one is armed, otherwise random stalls when enabled.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(rx_idle_on && $urandom_range(99) < 9);
      end
    end
  end

  always @(posedge clk) begin
    vdp_result_t got;
    vdp_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = vdp_result_t'(m_tdata[10:0]);
      if (expected_results.size() == 0) begin
        $error("unexpected output word %h", m_tdata);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.rd_data !== want.rd_data) begin
          $error("rd_data: expected %h, got %h", want.rd_data, got.rd_data);
          mismatch_count++;
        end
        if (got.nmi_action !== want.nmi_action) begin
          $error("nmi_action: expected %0d, got %0d", want.nmi_action, got.nmi_action);
          mismatch_count++;
        end
        if (got.irq_pending !== want.irq_pending) begin
          $error("irq_pending: expected %0d, got %0d", want.irq_pending, got.irq_pending);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_directed();
    // point the address at the top byte without a prefetch
    send_word(REQ_WR_CTRL, 8'hff, 9'd0);
    send_word(REQ_WR_CTRL, 8'h7f, 9'd0);
    // write the top byte, then wrap to zero
    send_word(REQ_WR_DATA, 8'hff, 9'd0);
    send_word(REQ_WR_DATA, 8'ha5, 9'h1ff);
    // set the top address again, this time with prefetch
    send_word(REQ_WR_CTRL, 8'hff, 9'd0);
    send_word(REQ_WR_CTRL, 8'h3f, 9'd0);
    send_word(REQ_RD_DATA, 8'h00, 9'd0);
    send_word(REQ_RD_DATA, 8'h00, 9'd0);
    // enable the interrupt while vblank is clear
    send_word(REQ_WR_CTRL, 8'h20, 9'd0);
    send_word(REQ_WR_CTRL, 8'h81, 9'd0);
    send_word(REQ_TICK, 8'h00, 9'd191);
    send_word(REQ_TICK, 8'h00, VBLANK_LINE);
    send_word(REQ_RD_STATUS, 8'h00, 9'd0);
    // vblank set and line past 192: re-enabling asserts the interrupt
    send_word(REQ_TICK, 8'h00, VBLANK_LINE);
    send_word(REQ_WR_CTRL, 8'h20, 9'd0);
    send_word(REQ_WR_CTRL, 8'h81, 9'd0);
    // current line exactly 192: no assert on re-enable
    send_word(REQ_TICK, 8'h00, 9'd191);
    send_word(REQ_WR_CTRL, 8'h20, 9'd0);
    send_word(REQ_WR_CTRL, 8'h81, 9'd0);
    // status read and data write both drop a half-written control pair
    send_word(REQ_WR_CTRL, 8'h00, 9'd0);
    send_word(REQ_RD_STATUS, 8'h00, 9'd0);
    send_word(REQ_WR_CTRL, 8'h11, 9'd0);
    send_word(REQ_WR_DATA, 8'h5a, 9'd0);
    for (int k = 5; k <= 7; k++) send_word(3'(k), 8'hff, 9'h1ff);
    send_word(REQ_TICK, 8'hff, 9'h1ff);
  endtask

  task automatic random_access();
    int         pick;
    logic [7:0] lo;
    logic [7:0] hi;
    pick = $urandom_range(99);
    lo   = 8'($urandom);
    if (pick < 30) begin
      // address load, about half the time into the low region so reads hit written bytes
      hi = {1'b0, 1'($urandom), ($urandom_range(1) ? 6'd0 : 6'($urandom))};
      if ($urandom_range(15) == 0) hi[5:0] = 6'h3f;
      send_word(REQ_WR_CTRL, lo, 9'($urandom));
      send_word(REQ_WR_CTRL, hi, 9'($urandom));
    end else if (pick < 38) begin
      hi = {1'b1, 4'($urandom), ($urandom_range(1) ? MODE_REG_IRQ : 3'($urandom))};
      send_word(REQ_WR_CTRL, lo, 9'($urandom));
      send_word(REQ_WR_CTRL, hi, 9'($urandom));
    end else if (pick < 58) begin
      send_word(REQ_WR_DATA, lo, 9'($urandom));
    end else if (pick < 76) begin
      send_word(REQ_RD_DATA, lo, 9'($urandom));
    end else if (pick < 82) begin
      send_word(REQ_RD_STATUS, lo, 9'($urandom));
    end else if (pick < 94) begin
      case ($urandom_range(9))
        0, 1, 2, 3: send_word(REQ_TICK, lo, VBLANK_LINE);
        4, 5:       send_word(REQ_TICK, lo, 9'd191);
        default:    send_word(REQ_TICK, lo, 9'($urandom));
      endcase
    end else if (pick < 97) begin
      send_word(REQ_WR_CTRL, lo, 9'($urandom));
    end else begin
      send_word(3'($urandom_range(7, 5)), lo, 9'($urandom));
    end
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) random_access();
  endtask

  task automatic test_no_idle_burst(input int unsigned count);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_traffic(count);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure(input int unsigned count);
    hold_left = HOLD_CYCLES;
    test_random_traffic(count);
  endtask

  initial begin
    clear_shadow();
    words_sent     = 0;
    mismatch_count = 0;
    hold_left      = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= REQ_RD_DATA;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(700);
    test_no_idle_burst(200);
    test_output_backpressure(60);
    test_random_traffic(70);
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog; the VRAM clearing pass alone covers all 16K bytes after reset
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
